@@ rtl/core/lav_pkg.sv @@
// Shared constants and types for the look-at view matrix block.
package lav_pkg;

    // Width of every coordinate on the input and result channels.
    localparam int COORD_W = 32;

    // Normalised magnitudes are brought into [2^29, 2^30) before squaring.
    localparam int MANT_W = 30;

    // Sum of three squared normalised magnitudes, and the width of its root.
    localparam int SQR_W  = 62;
    localparam int ROOT_W = 32;

    // Matrix row carried by a result beat.
    typedef enum logic [1:0] {
        ROW_0,
        ROW_1,
        ROW_2,
        ROW_TRANS
    } t_row;

endpackage

@@ rtl/core/lav_norm.sv @@
// Pipelined three-component vector normaliser: divides each component by the vector length.
module lav_norm #(
    parameter int VW        = 33,
    parameter int FRAC_BITS = 16,
    parameter int SW        = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [VW-1:0]        i_vec [3],
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_vec [3],
    output logic                        o_zero,
    output logic [SW-1:0]               o_side
);

    localparam int MW = lav_pkg::MANT_W;
    localparam int SQ = lav_pkg::SQR_W;
    localparam int LW = lav_pkg::ROOT_W;
    localparam int EW = VW + MW;
    localparam int NS = $clog2(EW);
    localparam int RS = SQ / 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + LW;
    localparam int TW = SW + 4;
    localparam int TZ = 3;

    // Tag carried alongside: side data, zero flag and the three signs.
    logic          r_sv [NS+1];
    logic [EW-1:0] r_sw [NS+1][3];
    logic [TW-1:0] r_st [NS+1];

    logic              r_av;
    logic [MW-1:0]     r_a  [3];
    logic [2*MW-1:0]   r_ap [3];
    logic [TW-1:0]     r_at;

    logic          r_rv [RS+1];
    logic [SQ-1:0] r_rn [RS+1];
    logic [SQ-1:0] r_rr [RS+1];
    logic [MW-1:0] r_rm [RS+1][3];
    logic [TW-1:0] r_rt [RS+1];

    logic          r_dv [QW+1];
    logic [DW-1:0] r_dr [QW+1][3];
    logic [QW-1:0] r_dq [QW+1][3];
    logic [LW-1:0] r_dl [QW+1];
    logic [TW-1:0] r_dt [QW+1];

    logic                        r_ov;
    logic signed [FRAC_BITS+1:0] r_ov_vec [3];
    logic [TW-1:0]               r_ot;

    logic [VW-1:0] w_mag [3];
    logic [LW-1:0] w_root;

    // Component magnitudes; the most negative value maps onto its own pattern.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_vec[i][VW-1] ? $unsigned(-i_vec[i]) : $unsigned(i_vec[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sw[0][i] <= EW'(w_mag[i]);
            end
            r_st[0] <= {i_side,
                        (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0),
                        i_vec[2][VW-1], i_vec[1][VW-1], i_vec[0][VW-1]};
        end
    end

    // Leading-one alignment: shift left by halving steps until the top bit is set.
    for (genvar j = 0; j < NS; j++) begin : g_align
        localparam int SH = 1 << (NS - 1 - j);
        logic [EW-1:0] w_or;
        logic          w_go;

        assign w_or = r_sw[j][0] | r_sw[j][1] | r_sw[j][2];
        assign w_go = (w_or[EW-1 -: SH] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sw[j+1][i] <= w_go ? (r_sw[j][i] << SH) : r_sw[j][i];
                end
                r_st[j+1] <= r_st[j];
            end
        end
    end

    // Squares of the top bits; a right shift truncates, a left shift is exact.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (i_en) begin
            r_av <= r_sv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i]  <= r_sw[NS][i][EW-1 -: MW];
                r_ap[i] <= r_sw[NS][i][EW-1 -: MW] * r_sw[NS][i][EW-1 -: MW];
            end
            r_at <= r_st[NS];
        end
    end

    // Sum of squares feeds the root stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (i_en) begin
            r_rv[0] <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rn[0] <= SQ'(r_ap[0]) + SQ'(r_ap[1]) + SQ'(r_ap[2]);
            r_rr[0] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_rm[0][i] <= r_a[i];
            end
            r_rt[0] <= r_at;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar k = 0; k < RS; k++) begin : g_root
        localparam int BP = SQ - 2 - 2 * k;
        localparam logic [SQ:0] BIT = (SQ + 1)'(1) << BP;
        logic [SQ:0] w_try;
        logic        w_ge;

        assign w_try = {1'b0, r_rr[k]} + BIT;
        assign w_ge  = ({1'b0, r_rn[k]} >= w_try);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_rv[k+1] <= r_rv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rn[k+1] <= w_ge ? (r_rn[k] - w_try[SQ-1:0]) : r_rn[k];
                r_rr[k+1] <= w_ge ? ((r_rr[k] >> 1) + BIT[SQ-1:0]) : (r_rr[k] >> 1);
                for (int i = 0; i < 3; i++) begin
                    r_rm[k+1][i] <= r_rm[k][i];
                end
                r_rt[k+1] <= r_rt[k];
            end
        end
    end

    assign w_root = r_rr[RS][LW-1:0];

    // Dividends with half the length added, so the quotient rounds to nearest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_rv[RS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i] <= (DW'(r_rm[RS][i]) << FRAC_BITS) + DW'(w_root >> 1);
                r_dq[0][i] <= '0;
            end
            r_dl[0] <= w_root;
            r_dt[0] <= r_rt[RS];
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int SHK = QW - 1 - k;
        logic [DW-1:0] w_dd;
        logic          w_ge [3];

        assign w_dd = DW'(r_dl[k]) << SHK;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_ge[i] = (r_dr[k][i] >= w_dd);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dr[k+1][i] <= w_ge[i] ? (r_dr[k][i] - w_dd) : r_dr[k][i];
                    r_dq[k+1][i] <= {r_dq[k][i][QW-2:0], w_ge[i]};
                end
                r_dl[k+1] <= r_dl[k];
                r_dt[k+1] <= r_dt[k];
            end
        end
    end

    // Signs restored; a zero vector gives a zero result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dt[QW][TZ]) begin
                    r_ov_vec[i] <= '0;
                end else if (r_dt[QW][i]) begin
                    r_ov_vec[i] <= -$signed({1'b0, r_dq[QW][i]});
                end else begin
                    r_ov_vec[i] <= $signed({1'b0, r_dq[QW][i]});
                end
            end
            r_ot <= r_dt[QW];
        end
    end

    assign o_valid = r_ov;
    assign o_vec   = r_ov_vec;
    assign o_zero  = r_ot[TZ];
    assign o_side  = r_ot[TW-1:4];

    // After alignment the largest magnitude has its top bit set.
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv[NS] && !r_st[NS][TZ]) |->
            (r_sw[NS][0][EW-1] || r_sw[NS][1][EW-1] || r_sw[NS][2][EW-1]))
        else $error("normaliser: alignment left the top bit clear");

    // The vector length lies in [2^29, 2^31) for any non-zero vector.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rv[RS] && !r_rt[RS][TZ]) |->
            ((r_rr[RS][SQ-1:LW-1] == '0) && (r_rr[RS][LW-2:LW-3] != '0)))
        else $error("normaliser: square root out of range");

    // No quotient exceeds one in fixed point.
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[QW] && !r_dt[QW][TZ]) |->
            ((!r_dq[QW][0][QW-1] || (r_dq[QW][0][QW-2:0] == '0)) &&
             (!r_dq[QW][1][QW-1] || (r_dq[QW][1][QW-2:0] == '0)) &&
             (!r_dq[QW][2][QW-1] || (r_dq[QW][2][QW-2:0] == '0))))
        else $error("normaliser: quotient above one");

endmodule

@@ rtl/core/look_at_view_matrix.sv @@
// Look-at view matrix builder: camera, target and up vector in, four matrix rows out.
//
// Each accepted beat of camera, target and up vector (signed fixed point with FRAC_BITS
// fraction bits) produces four result beats, rows 0 to 3 of the view matrix, in order.
// The basis vectors are formed by three normalisers in series, each with a bit-per-stage
// square root and a bit-per-stage divider, with a cross product between each pair and the
// translation dot products at the end. The four-row output register sets the sustained
// rate at one input beat for every four result beats; inputs can be taken in consecutive
// cycles while the pipeline has room. Stall on the result side holds the pipeline once a
// finished matrix waits at its end, without losing or repeating any beat.
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_cam_x,
    input  logic [31:0] i_cam_y,
    input  logic [31:0] i_cam_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_up_x,
    input  logic [31:0] i_up_y,
    input  logic [31:0] i_up_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_row_index,
    output logic [31:0] o_col0,
    output logic [31:0] o_col1,
    output logic [31:0] o_col2,
    output logic [31:0] o_col3,
    output logic        o_last_row,
    output logic        o_degenerate,
    output logic        o_saturated
);

    localparam int CW  = lav_pkg::COORD_W;
    localparam int BW  = FRAC_BITS + 2;
    localparam int V1  = CW + 1;
    localparam int P1W = CW + BW;
    localparam int V2  = P1W + 1;
    localparam int P2W = 2 * BW;
    localparam int V3  = P2W + 1;
    localparam int DPW = BW + CW;
    localparam int DSW = DPW + 2;
    localparam int RW  = DSW + 1 - FRAC_BITS;
    localparam int S1W = 6 * CW;
    localparam int S2W = 3 * BW + 3 * CW + 1;
    localparam int S3W = 6 * BW + 3 * CW + 1;
    localparam logic [DSW:0]    HALF    = (DSW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [CW-1:0]   MAX_POS = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0]   MIN_NEG = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [CW-1:0]   ONE     = CW'(1) << FRAC_BITS;

    logic w_en;
    logic w_take;

    // Input stage: camera minus target at full width.
    logic                 r_v0;
    logic signed [V1-1:0] r_dz [3];
    logic [S1W-1:0]       r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dz[0] <= {i_cam_x[CW-1], i_cam_x} - {i_target_x[CW-1], i_target_x};
            r_dz[1] <= {i_cam_y[CW-1], i_cam_y} - {i_target_y[CW-1], i_target_y};
            r_dz[2] <= {i_cam_z[CW-1], i_cam_z} - {i_target_z[CW-1], i_target_z};
            r_s0    <= {i_cam_x, i_cam_y, i_cam_z, i_up_x, i_up_y, i_up_z};
        end
    end

    // First normaliser gives the z basis vector.
    logic                 n1_valid;
    logic signed [BW-1:0] n1_vec [3];
    logic                 n1_zero;
    logic [S1W-1:0]       n1_side;

    lav_norm #(.VW(V1), .FRAC_BITS(FRAC_BITS), .SW(S1W)) u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v0),
        .i_vec   (r_dz),
        .i_side  (r_s0),
        .o_valid (n1_valid),
        .o_vec   (n1_vec),
        .o_zero  (n1_zero),
        .o_side  (n1_side)
    );

    logic signed [CW-1:0] w_cam1 [3];
    logic signed [CW-1:0] w_up1  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cam1[i] = n1_side[S1W-1-CW*i -: CW];
            w_up1[i]  = n1_side[3*CW-1-CW*i -: CW];
        end
    end

    // Up cross z: products, then differences.
    logic                  r_p1v;
    logic signed [P1W-1:0] r_p1 [6];
    logic signed [BW-1:0]  r_p1z [3];
    logic [3*CW-1:0]       r_p1cam;
    logic                  r_p1deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
        end else if (w_en) begin
            r_p1v <= n1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1[0] <= w_up1[1] * n1_vec[2];
            r_p1[1] <= w_up1[2] * n1_vec[1];
            r_p1[2] <= w_up1[2] * n1_vec[0];
            r_p1[3] <= w_up1[0] * n1_vec[2];
            r_p1[4] <= w_up1[0] * n1_vec[1];
            r_p1[5] <= w_up1[1] * n1_vec[0];
            r_p1z   <= n1_vec;
            r_p1cam <= n1_side[S1W-1 -: 3*CW];
            r_p1deg <= n1_zero;
        end
    end

    logic                 r_c1v;
    logic signed [V2-1:0] r_c1 [3];
    logic [S2W-1:0]       r_c1s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1v <= 1'b0;
        end else if (w_en) begin
            r_c1v <= r_p1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_c1[i] <= V2'(r_p1[2*i]) - V2'(r_p1[2*i+1]);
            end
            r_c1s <= {r_p1z[0], r_p1z[1], r_p1z[2], r_p1cam, r_p1deg};
        end
    end

    // Second normaliser gives the x basis vector.
    logic                 n2_valid;
    logic signed [BW-1:0] n2_vec [3];
    logic                 n2_zero;
    logic [S2W-1:0]       n2_side;

    lav_norm #(.VW(V2), .FRAC_BITS(FRAC_BITS), .SW(S2W)) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c1v),
        .i_vec   (r_c1),
        .i_side  (r_c1s),
        .o_valid (n2_valid),
        .o_vec   (n2_vec),
        .o_zero  (n2_zero),
        .o_side  (n2_side)
    );

    logic signed [BW-1:0] w_z2 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_z2[i] = n2_side[S2W-1-BW*i -: BW];
        end
    end

    // z cross x: products, then differences.
    logic                  r_p2v;
    logic signed [P2W-1:0] r_p2 [6];
    logic signed [BW-1:0]  r_p2z [3];
    logic signed [BW-1:0]  r_p2x [3];
    logic [3*CW-1:0]       r_p2cam;
    logic                  r_p2deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2v <= 1'b0;
        end else if (w_en) begin
            r_p2v <= n2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2[0] <= w_z2[1] * n2_vec[2];
            r_p2[1] <= w_z2[2] * n2_vec[1];
            r_p2[2] <= w_z2[2] * n2_vec[0];
            r_p2[3] <= w_z2[0] * n2_vec[2];
            r_p2[4] <= w_z2[0] * n2_vec[1];
            r_p2[5] <= w_z2[1] * n2_vec[0];
            r_p2z   <= w_z2;
            r_p2x   <= n2_vec;
            r_p2cam <= n2_side[3*CW:1];
            r_p2deg <= n2_side[0] | n2_zero;
        end
    end

    logic                 r_c2v;
    logic signed [V3-1:0] r_c2 [3];
    logic [S3W-1:0]       r_c2s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2v <= 1'b0;
        end else if (w_en) begin
            r_c2v <= r_p2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_c2[i] <= V3'(r_p2[2*i]) - V3'(r_p2[2*i+1]);
            end
            r_c2s <= {r_p2z[0], r_p2z[1], r_p2z[2], r_p2x[0], r_p2x[1], r_p2x[2],
                      r_p2cam, r_p2deg};
        end
    end

    // Third normaliser gives the y basis vector.
    logic                 n3_valid;
    logic signed [BW-1:0] n3_vec [3];
    logic                 n3_zero;
    logic [S3W-1:0]       n3_side;

    lav_norm #(.VW(V3), .FRAC_BITS(FRAC_BITS), .SW(S3W)) u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c2v),
        .i_vec   (r_c2),
        .i_side  (r_c2s),
        .o_valid (n3_valid),
        .o_vec   (n3_vec),
        .o_zero  (n3_zero),
        .o_side  (n3_side)
    );

    logic signed [BW-1:0] w_z3   [3];
    logic signed [BW-1:0] w_x3   [3];
    logic signed [CW-1:0] w_cam3 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_z3[i]   = n3_side[S3W-1-BW*i -: BW];
            w_x3[i]   = n3_side[S3W-1-3*BW-BW*i -: BW];
            w_cam3[i] = n3_side[3*CW-CW*i -: CW];
        end
    end

    // Translation: nine products of basis and camera.
    logic                  r_d1v;
    logic signed [DPW-1:0] r_d1x [3];
    logic signed [DPW-1:0] r_d1y [3];
    logic signed [DPW-1:0] r_d1z [3];
    logic signed [BW-1:0]  r_d1bx [3];
    logic signed [BW-1:0]  r_d1by [3];
    logic signed [BW-1:0]  r_d1bz [3];
    logic                  r_d1deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1v <= 1'b0;
        end else if (w_en) begin
            r_d1v <= n3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d1x[i] <= w_x3[i] * w_cam3[i];
                r_d1y[i] <= n3_vec[i] * w_cam3[i];
                r_d1z[i] <= w_z3[i] * w_cam3[i];
            end
            r_d1bx  <= w_x3;
            r_d1by  <= n3_vec;
            r_d1bz  <= w_z3;
            r_d1deg <= n3_side[0] | n3_zero;
        end
    end

    // Translation: dot product sums.
    logic                  r_d2v;
    logic signed [DSW-1:0] r_d2 [3];
    logic signed [BW-1:0]  r_d2bx [3];
    logic signed [BW-1:0]  r_d2by [3];
    logic signed [BW-1:0]  r_d2bz [3];
    logic                  r_d2deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2v <= 1'b0;
        end else if (w_en) begin
            r_d2v <= r_d1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2[0] <= DSW'(r_d1x[0]) + DSW'(r_d1x[1]) + DSW'(r_d1x[2]);
            r_d2[1] <= DSW'(r_d1y[0]) + DSW'(r_d1y[1]) + DSW'(r_d1y[2]);
            r_d2[2] <= DSW'(r_d1z[0]) + DSW'(r_d1z[1]) + DSW'(r_d1z[2]);
            r_d2bx  <= r_d1bx;
            r_d2by  <= r_d1by;
            r_d2bz  <= r_d1bz;
            r_d2deg <= r_d1deg;
        end
    end

    // Translation: round half away from zero, negate and clip to 32 bits.
    logic [DSW-1:0] w_dmag [3];
    logic [DSW:0]   w_dsum [3];
    logic [RW-1:0]  w_dr   [3];
    logic [CW-1:0]  w_t    [3];
    logic [2:0]     w_tsat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dmag[i] = r_d2[i][DSW-1] ? $unsigned(-r_d2[i]) : $unsigned(r_d2[i]);
            w_dsum[i] = {1'b0, w_dmag[i]} + HALF;
            w_dr[i]   = w_dsum[i][DSW:FRAC_BITS];
            if (r_d2[i][DSW-1]) begin
                w_tsat[i] = (w_dr[i][RW-1:CW-1] != '0);
                w_t[i]    = w_tsat[i] ? MAX_POS : w_dr[i][CW-1:0];
            end else begin
                w_tsat[i] = (w_dr[i][RW-1:CW] != '0) ||
                            (w_dr[i][CW-1] && (w_dr[i][CW-2:0] != '0));
                w_t[i]    = w_tsat[i] ? MIN_NEG : (CW'(0) - w_dr[i][CW-1:0]);
            end
        end
    end

    logic                 r_d3v;
    logic [CW-1:0]        r_d3t [3];
    logic signed [BW-1:0] r_d3bx [3];
    logic signed [BW-1:0] r_d3by [3];
    logic signed [BW-1:0] r_d3bz [3];
    logic                 r_d3deg;
    logic                 r_d3sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d3v <= 1'b0;
        end else if (w_en) begin
            r_d3v <= r_d2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d3t   <= w_t;
            r_d3bx  <= r_d2bx;
            r_d3by  <= r_d2by;
            r_d3bz  <= r_d2bz;
            r_d3deg <= r_d2deg;
            r_d3sat <= |w_tsat;
        end
    end

    // Output register: holds one matrix and sends it as four row beats.
    logic                 r_busy;
    lav_pkg::t_row        r_row;
    logic [CW-1:0]        r_ot [3];
    logic signed [BW-1:0] r_ox [3];
    logic signed [BW-1:0] r_oy [3];
    logic signed [BW-1:0] r_oz [3];
    logic                 r_odeg;
    logic                 r_osat;

    assign w_take  = !r_busy || ((r_row == lav_pkg::ROW_TRANS) && !i_stall);
    assign w_en    = !r_d3v || w_take;
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= lav_pkg::ROW_0;
        end else if (r_d3v && w_take) begin
            r_busy <= 1'b1;
            r_row  <= lav_pkg::ROW_0;
        end else if (r_busy && !i_stall) begin
            if (r_row == lav_pkg::ROW_TRANS) begin
                r_busy <= 1'b0;
            end
            r_row <= lav_pkg::t_row'(r_row + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d3v && w_take) begin
            r_ot   <= r_d3t;
            r_ox   <= r_d3bx;
            r_oy   <= r_d3by;
            r_oz   <= r_d3bz;
            r_odeg <= r_d3deg;
            r_osat <= r_d3sat;
        end
    end

    // Row selection for the current beat.
    always_comb begin
        unique case (r_row)
            lav_pkg::ROW_0: begin
                o_col0 = CW'(r_ox[0]);
                o_col1 = CW'(r_oy[0]);
                o_col2 = CW'(r_oz[0]);
                o_col3 = '0;
            end
            lav_pkg::ROW_1: begin
                o_col0 = CW'(r_ox[1]);
                o_col1 = CW'(r_oy[1]);
                o_col2 = CW'(r_oz[1]);
                o_col3 = '0;
            end
            lav_pkg::ROW_2: begin
                o_col0 = CW'(r_ox[2]);
                o_col1 = CW'(r_oy[2]);
                o_col2 = CW'(r_oz[2]);
                o_col3 = '0;
            end
            lav_pkg::ROW_TRANS: begin
                o_col0 = r_ot[0];
                o_col1 = r_ot[1];
                o_col2 = r_ot[2];
                o_col3 = ONE;
            end
            default: begin
                o_col0 = '0;
                o_col1 = '0;
                o_col2 = '0;
                o_col3 = '0;
            end
        endcase
    end

    assign o_valid      = r_busy;
    assign o_row_index  = r_row;
    assign o_last_row   = (r_row == lav_pkg::ROW_TRANS);
    assign o_degenerate = r_odeg;
    assign o_saturated  = r_osat;

    // Rows advance one at a time within a matrix.
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (o_row_index != lav_pkg::ROW_TRANS)) |=>
            (o_valid && (o_row_index == 2'($past(o_row_index) + 2'd1))))
        else $error("view matrix: row beats out of order");

    // After the translation row the next beat, if any, starts a new matrix.
    a_new_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (o_row_index == lav_pkg::ROW_TRANS)) |=>
            (!o_valid || (o_row_index == lav_pkg::ROW_0)))
        else $error("view matrix: new matrix does not start at row 0");

    // Input is held back only while a finished matrix waits at the pipeline end.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_d3v && r_busy))
        else $error("view matrix: input stalled with nothing waiting");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the look-at view matrix block.
module tb_top;

    localparam int FRAC   = 16;
    localparam int N_RAND = 240;
    localparam int PAUSE_AT = 150;
    localparam int HOLD_AFTER = 60;
    localparam int HOLD_LEN = 700;
    localparam logic [31:0] ONE = 32'h0001_0000;

    typedef struct {
        logic [31:0] v [9];   // cam xyz, target xyz, up xyz
        bit          known;   // expected rows are the degenerate set rather than predicted
    } cam_item_t;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] c0, c1, c2, c3;
        logic        last, deg, sat;
    } row_beat_t;

    typedef longint vec3_t [3];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [31:0] pay [9] = '{default: 32'h0};
    logic        o_stall, o_valid, o_last_row, o_degenerate, o_saturated;
    logic [1:0]  o_row_index;
    logic [31:0] o_col0, o_col1, o_col2, o_col3;

    cam_item_t   items [$];
    row_beat_t   matrix_rows_q [$];
    int          nxt = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          held = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    int          n_fail = 0;
    bit          run_live = 0;

    look_at_view_matrix #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cam_x(pay[0]), .i_cam_y(pay[1]), .i_cam_z(pay[2]),
        .i_target_x(pay[3]), .i_target_y(pay[4]), .i_target_z(pay[5]),
        .i_up_x(pay[6]), .i_up_y(pay[7]), .i_up_z(pay[8]),
        .o_valid(o_valid), .i_stall(i_stall), .o_row_index(o_row_index),
        .o_col0(o_col0), .o_col1(o_col1), .o_col2(o_col2), .o_col3(o_col3),
        .o_last_row(o_last_row), .o_degenerate(o_degenerate), .o_saturated(o_saturated)
    );

    // Clock with a period of 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit vector by division by the length; returns 1 for a zero vector.
    function automatic bit unit_vec(input vec3_t v, output vec3_t o);
        longint unsigned m [3];
        longint unsigned mx, s, len, q;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            o = '{0, 0, 0};
            return 1'b1;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic vec3_t cross_prod(vec3_t a, vec3_t b);
        vec3_t o;
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
        return o;
    endfunction

    // Negated dot with the camera, rounded half away from zero and clipped.
    function automatic logic [31:0] trans_term(vec3_t a, vec3_t cam, inout bit sat);
        longint d;
        longint unsigned r;
        d = a[0] * cam[0] + a[1] * cam[1] + a[2] * cam[2];
        r = (((d < 0) ? -d : d) + (64'd1 << (FRAC - 1))) >> FRAC;
        if (d < 0) begin
            if (r > 64'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return r[31:0];
        end
        if (r > 64'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -r[31:0];
    endfunction

    // Work out the four view matrix rows of one camera beat.
    task automatic predict_view_rows(cam_item_t it);
        vec3_t cam, up, dz, zb, xb, yb;
        logic [31:0] t [3];
        bit deg, sat;
        row_beat_t rb;
        deg = 0;
        sat = 0;
        for (int i = 0; i < 3; i++) begin
            cam[i] = longint'($signed(it.v[i]));
            dz[i]  = cam[i] - longint'($signed(it.v[3 + i]));
            up[i]  = longint'($signed(it.v[6 + i]));
        end
        deg |= unit_vec(dz, zb);
        deg |= unit_vec(cross_prod(up, zb), xb);
        deg |= unit_vec(cross_prod(zb, xb), yb);
        t[0] = trans_term(xb, cam, sat);
        t[1] = trans_term(yb, cam, sat);
        t[2] = trans_term(zb, cam, sat);
        for (int r = 0; r < 4; r++) begin
            rb.row  = r[1:0];
            rb.last = (r == 3);
            rb.deg  = deg;
            rb.sat  = sat;
            if (r < 3) begin
                rb.c0 = xb[r][31:0];
                rb.c1 = yb[r][31:0];
                rb.c2 = zb[r][31:0];
                rb.c3 = 32'h0;
            end else begin
                rb.c0 = t[0];
                rb.c1 = t[1];
                rb.c2 = t[2];
                rb.c3 = ONE;
            end
            matrix_rows_q.push_back(rb);
        end
    endtask

    // A camera sitting on its target gives an all-zero basis and translation.
    task automatic push_degenerate_rows();
        row_beat_t rb;
        for (int r = 0; r < 4; r++) begin
            rb = '{row: r[1:0], c0: 0, c1: 0, c2: 0, c3: (r == 3) ? ONE : 32'h0,
                   last: (r == 3), deg: 1'b1, sat: 1'b0};
            matrix_rows_q.push_back(rb);
        end
    endtask

    task automatic add_item(logic [31:0] c0, c1, c2, t0, t1, t2, u0, u1, u2, bit kn);
        cam_item_t it;
        it.v = '{c0, c1, c2, t0, t1, t2, u0, u1, u2};
        it.known = kn;
        items.push_back(it);
    endtask

    function automatic logic [31:0] small_val();
        return $unsigned(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    // Directed table, then random beats.
    initial begin
        logic [31:0] r [9];
        int k;
        // Camera on target at the origin, and camera on target elsewhere.
        add_item(0, 0, 0, 0, 0, 0, 0, ONE, 0, 1);
        add_item(32'h7FFF_FFFF, 32'h8000_0000, 5, 32'h7FFF_FFFF, 32'h8000_0000, 5,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        // Axis aligned views.
        add_item(0, 0, ONE, 0, 0, 0, 0, ONE, 0, 0);
        add_item(ONE, 0, 0, 0, 0, 0, 0, 0, ONE, 0);
        add_item(0, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
        // Up parallel to the view direction: x and y collapse.
        add_item(0, 0, 32'h0003_0000, 0, 0, 0, 0, 0, ONE, 0);
        add_item(ONE, ONE, ONE, 0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 0);
        // Zero up vector.
        add_item(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0, 0);
        // Field extremes, widest difference and translation clipping.
        add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 0);
        add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, ONE, 0, 0);
        add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, ONE, 0, 0, 0);
        add_item(1, 0, 0, 0, 0, 0, 0, 1, 0, 0);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
                 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
        add_item(32'h0123_4567, 32'h89AB_CDEF, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h3333_3333, 32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1, 0);
        for (int n = 0; n < N_RAND; n++) begin
            k = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++) r[i] = (k <= 2) ? $urandom() : small_val();
            if (k == 7) begin
                for (int i = 0; i < 3; i++) r[3 + i] = r[i];
            end else if (k == 8) begin
                for (int i = 0; i < 3; i++) r[6 + i] = (r[i] - r[3 + i]) <<< 1;
            end else if (k == 9) begin
                for (int i = 0; i < 3; i++) r[i] = $urandom();
                for (int i = 0; i < 3; i++) r[3 + i] = r[i] + small_val();
            end
            add_item(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 0);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_live = 1;
        wait (nxt == items.size() && matrix_rows_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (n_fail == 0 && matrix_rows_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Sender: bursts and gaps, plus one pause until the pipeline drains.
    always @(posedge i_clk) begin
        if (run_live) begin
            if (i_valid && !o_stall) begin
                if (items[nxt].known) push_degenerate_rows();
                else predict_view_rows(items[nxt]);
                nxt++;
            end
            if (!(i_valid && o_stall)) begin
                if (nxt == items.size()) begin
                    i_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (nxt == PAUSE_AT && matrix_rows_q.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    pay <= items[nxt].v;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: random stall modes and one long hold that backs up the pipeline.
    always @(posedge i_clk) begin
        if (run_live) begin
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held && nxt >= HOLD_AFTER) begin
                held = 1;
                hold_left = HOLD_LEN;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic check_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", nm, exp_v, act_v);
            n_fail++;
        end
    endtask

    // Compare each result beat with the oldest predicted row.
    always @(posedge i_clk) begin
        row_beat_t e;
        if (run_live && o_valid && !i_stall) begin
            if (matrix_rows_q.size() == 0) begin
                $error("row beat with no prediction waiting");
                n_fail++;
            end else begin
                e = matrix_rows_q.pop_front();
                check_field("row_index", e.row, o_row_index);
                check_field("col0", e.c0, o_col0);
                check_field("col1", e.c1, o_col1);
                check_field("col2", e.c2, o_col2);
                check_field("col3", e.c3, o_col3);
                check_field("last_row", e.last, o_last_row);
                check_field("degenerate", e.deg, o_degenerate);
                check_field("saturated", e.sat, o_saturated);
            end
        end
    end

    // Watchdog.
    initial begin
        #(20 * 400_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
